// File: src/timed_note_event_pool_core_defines.svh
// assertion macros for the timed note event pool core
`ifndef TIMED_NOTE_EVENT_POOL_CORE_DEFINES_SVH
`define TIMED_NOTE_EVENT_POOL_CORE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication checked on every clock edge outside reset
`define TNEP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tnep same-cycle check failed");
// next-cycle implication checked on every clock edge outside reset
`define TNEP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tnep next-cycle check failed");
`else
`define TNEP_ASSERT_IMP(lbl, ante, cons)
`define TNEP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: src/tnep_pkg.sv
// shared types and codes for the timed note event pool
package tnep_pkg;

  // internal operation codes
  localparam logic [1:0] OP_SCHED   = 2'd0;
  localparam logic [1:0] OP_SERVICE = 2'd1;
  localparam logic [1:0] OP_FLUSH   = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  // input mode codes
  localparam logic [1:0] MODE_SCHED   = 2'd0;
  localparam logic [1:0] MODE_SERVICE = 2'd1;
  localparam logic [1:0] MODE_FLUSH   = 2'd2;
  localparam logic [1:0] MODE_CLEAR   = 2'd3;

  // result kind codes
  localparam logic [2:0] RK_OFF     = 3'd0;
  localparam logic [2:0] RK_ON      = 3'd1;
  localparam logic [2:0] RK_STORED  = 3'd2;
  localparam logic [2:0] RK_DROPPED = 3'd3;
  localparam logic [2:0] RK_NONE    = 3'd4;

  // command queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;

  typedef struct packed {
    logic        is_on;
    logic [1:0]  dest;
    logic [4:0]  chan;
    logic [13:0] note_vel;
  } entry_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] tick;
    entry_t      ent;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] dest;
    logic [4:0] chan;
    logic [6:0] note;
    logic [6:0] vel;
  } result_t;

  // front to queue
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_push_t;

  // queue status
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

// File: src/tnep_if.sv
// channel interfaces for request and response beats
interface tnep_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] event_tick;
  logic        event_kind;
  logic [1:0]  destination;
  logic [4:0]  channel;
  logic [6:0]  note_number;
  logic [6:0]  velocity;

  modport source (
    output valid, mode, event_tick, event_kind, destination, channel, note_number, velocity,
    input  ready
  );
  modport sink (
    input  valid, mode, event_tick, event_kind, destination, channel, note_number, velocity,
    output ready
  );
endinterface

interface tnep_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [1:0] out_destination;
  logic [4:0] out_channel;
  logic [6:0] out_note;
  logic [6:0] out_velocity;
  logic       last;

  modport source (
    output valid, result_kind, out_destination, out_channel, out_note, out_velocity, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, out_destination, out_channel, out_note, out_velocity, last,
    output ready
  );
endinterface

// File: src/tnep_front.sv
// request front end: accepts beats, decodes the mode and packs the event
module tnep_front (
  tnep_in_if.sink          req,
  input  tnep_pkg::q_stat_t qs,
  output tnep_pkg::q_push_t push
);
  import tnep_pkg::*;

  logic [1:0] op;

  // mode decode
  always_comb begin
    unique case (req.mode)
      MODE_SCHED:   op = OP_SCHED;
      MODE_SERVICE: op = OP_SERVICE;
      MODE_FLUSH:   op = OP_FLUSH;
      MODE_CLEAR:   op = OP_CLEAR;
      default:      op = OP_CLEAR;
    endcase
  end

  // accept whenever the queue has room
  assign req.ready = !qs.full;

  // pack the command
  always_comb begin
    push.push              = req.valid && !qs.full;
    push.cmd.op            = op;
    push.cmd.tick          = req.event_tick;
    push.cmd.ent.is_on     = req.event_kind;
    push.cmd.ent.dest      = req.destination;
    push.cmd.ent.chan      = req.channel;
    push.cmd.ent.note_vel  = {req.note_number, req.velocity};
  end

endmodule

// File: src/tnep_cmd_fifo.sv
// short command queue between front end and pool engine
module tnep_cmd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  tnep_pkg::q_push_t push,
  input  logic              pop,
  output tnep_pkg::q_stat_t qs,
  output tnep_pkg::cmd_t    head
);
  import tnep_pkg::*;

  cmd_t                 qmem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   do_push;
  logic                   do_pop;

  assign qs.full  = (count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign qs.valid = (count != '0);
  assign head     = qmem[rd_ptr];
  assign do_push  = push.push && !qs.full;
  assign do_pop   = pop && qs.valid;

  // storage write
  always_ff @(posedge clk) begin
    if (do_push) begin
      qmem[wr_ptr] <= push.cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QUEUE_PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QUEUE_PTR_W + 1)'(1);
      end
    end
  end

endmodule

// File: src/tnep_back.sv
// pool engine: slot store, scans for schedule/service/flush, result output
module tnep_back #(
  parameter int POOL_SLOTS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  tnep_pkg::cmd_t q_cmd,
  output logic           q_pop,
  tnep_out_if.source     rsp
);
  import tnep_pkg::*;

  localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_SLOTS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  typedef struct packed {
    logic [31:0] due;
    entry_t      ent;
  } slot_t;

  slot_t                  mem [POOL_SLOTS];
  slot_t                  rd_slot;
  logic [POOL_SLOTS-1:0]  used;
  logic [1:0]             st;
  cmd_t                   cur;
  logic                   pass;
  logic                   iss;
  logic [IDX_W-1:0]       scan_idx;
  logic [IDX_W-1:0]       chk_idx;
  logic                   chk_vld;
  logic                   hold_vld;
  result_t                hold;
  logic                   o_vld;
  result_t                o_res;
  logic                   o_last;

  logic    can_push;
  logic    svc;
  logic    sched;
  logic    due_ok;
  logic    chk_used;
  logic    hit_emit;
  logic    hit_drop;
  logic    stall;
  logic    advance;
  logic    rd_en;
  logic    emit_push;
  logic    fin_push;
  logic    free_here;
  logic    drained;
  logic [31:0] tick_diff;
  result_t slot_res;

  // status result with empty payload
  function automatic result_t status_res(input logic [2:0] kind);
    result_t r;
    r      = '0;
    r.kind = kind;
    return r;
  endfunction

  // decode and qualify the check stage
  always_comb begin
    can_push  = !o_vld || rsp.ready;
    svc       = (cur.op == OP_SERVICE);
    sched     = (cur.op == OP_SCHED);
    tick_diff = cur.tick - rd_slot.due;
    due_ok    = !tick_diff[31];
    chk_used  = used[chk_idx];
    hit_emit  = chk_vld && chk_used &&
                (svc ? ((rd_slot.ent.is_on == pass) && due_ok) : !rd_slot.ent.is_on);
    hit_drop  = chk_vld && chk_used && !svc && rd_slot.ent.is_on;
    stall     = hit_emit && hold_vld && !can_push;
    advance   = (st == ST_SCAN) && !sched && !stall;
    rd_en     = advance && iss;
    drained   = !iss && !chk_vld;
    emit_push = (st == ST_SCAN) && !sched && !drained && hit_emit && hold_vld && can_push;
    fin_push  = (st == ST_FIN) && can_push;
    free_here = !used[scan_idx];
    q_pop     = (st == ST_IDLE) && q_valid;
  end

  // event result from the slot read data
  always_comb begin
    slot_res.kind = rd_slot.ent.is_on ? RK_ON : RK_OFF;
    slot_res.dest = rd_slot.ent.dest;
    slot_res.chan = rd_slot.ent.chan;
    slot_res.note = rd_slot.ent.note_vel[13:7];
    slot_res.vel  = rd_slot.ent.is_on ? rd_slot.ent.note_vel[6:0] : 7'd0;
  end

  // slot memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if ((st == ST_SCAN) && sched && free_here) begin
      mem[scan_idx] <= '{due: cur.tick, ent: cur.ent};
    end
    if (rd_en) begin
      rd_slot <= mem[scan_idx];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      used     <= '0;
      hold_vld <= 1'b0;
      chk_vld  <= 1'b0;
      iss      <= 1'b0;
      pass     <= 1'b0;
      scan_idx <= '0;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (q_valid) begin
            cur      <= q_cmd;
            scan_idx <= '0;
            pass     <= 1'b0;
            iss      <= 1'b1;
            chk_vld  <= 1'b0;
            if (q_cmd.op == OP_CLEAR) begin
              used <= '0;
              st   <= ST_FIN;
            end else begin
              st <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (sched) begin
            // lowest free slot search, one slot a cycle
            if (free_here) begin
              used[scan_idx] <= 1'b1;
              hold           <= status_res(RK_STORED);
              hold_vld       <= 1'b1;
              st             <= ST_FIN;
            end else if (scan_idx == LAST_IDX) begin
              hold     <= status_res(RK_DROPPED);
              hold_vld <= 1'b1;
              st       <= ST_FIN;
            end else begin
              scan_idx <= scan_idx + IDX_W'(1);
            end
          end else if (drained) begin
            // end of pass: offs pass then ons pass for service
            if (svc && !pass) begin
              pass     <= 1'b1;
              iss      <= 1'b1;
              scan_idx <= '0;
            end else begin
              st <= ST_FIN;
            end
          end else if (advance) begin
            if (hit_emit || hit_drop) begin
              used[chk_idx] <= 1'b0;
            end
            if (hit_emit) begin
              hold     <= slot_res;
              hold_vld <= 1'b1;
            end
            chk_vld <= iss;
            chk_idx <= scan_idx;
            if (iss) begin
              if (scan_idx == LAST_IDX) begin
                iss <= 1'b0;
              end else begin
                scan_idx <= scan_idx + IDX_W'(1);
              end
            end
          end
        end
        ST_FIN: begin
          if (can_push) begin
            hold_vld <= 1'b0;
            st       <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (emit_push || fin_push) begin
      o_vld <= 1'b1;
    end else if (rsp.ready) begin
      o_vld <= 1'b0;
    end
  end

  // output register payload; held result goes out, last only at run end
  always_ff @(posedge clk) begin
    if (emit_push) begin
      o_res  <= hold;
      o_last <= 1'b0;
    end else if (fin_push) begin
      o_res  <= hold_vld ? hold : status_res(RK_NONE);
      o_last <= 1'b1;
    end
  end

  assign rsp.valid           = o_vld;
  assign rsp.result_kind     = o_res.kind;
  assign rsp.out_destination = o_res.dest;
  assign rsp.out_channel     = o_res.chan;
  assign rsp.out_note        = o_res.note;
  assign rsp.out_velocity    = o_res.vel;
  assign rsp.last            = o_last;

endmodule

// File: src/timed_note_event_pool_core.sv
// top level of the timed note event pool
//
//   channel  dir  beat
//   req      in   mode, event_tick, event_kind, destination, channel, note_number, velocity
//   rsp      out  result_kind, out_destination, out_channel, out_note, out_velocity, last
//
// schedule: a free slot search, one slot a cycle, lowest index first.
// service: two passes through the slot memory read port (offs then ons);
//   flush: one pass that emits offs and drops ons; clear: no pass.
// reset clears the used bits directly; no clearing pass, slot payload is not reset.
// a two-entry command queue keeps req open while rsp stalls until it fills; the engine holds mid-scan.
`include "timed_note_event_pool_core_defines.svh"

module timed_note_event_pool_core #(
  parameter int POOL_SLOTS = 32
) (
  input  logic       clk,
  input  logic       rst,
  tnep_in_if.sink    req,
  tnep_out_if.source rsp
);
  import tnep_pkg::*;

  q_push_t push;
  q_stat_t qs;
  cmd_t    head;
  logic    q_pop;

  // front end
  tnep_front u_front (
    .req  (req),
    .qs   (qs),
    .push (push)
  );

  // command queue
  tnep_cmd_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (q_pop),
    .qs   (qs),
    .head (head)
  );

  // pool engine
  tnep_back #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (qs.valid),
    .q_cmd   (head),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

  // checks; status kinds are stored, dropped and none, the codes from stored up
  `TNEP_ASSERT_IMP(a_full_blocks, qs.full, !req.ready)
  `TNEP_ASSERT_NXT(a_accept_queued, req.valid && req.ready, qs.valid)
  `TNEP_ASSERT_IMP(a_status_last, rsp.valid && (rsp.result_kind >= RK_STORED), rsp.last)
  `TNEP_ASSERT_IMP(a_off_no_vel, rsp.valid && rsp.result_kind == RK_OFF, rsp.out_velocity == 7'd0)

endmodule
